// ===== hdl/lsnw_pkg.sv =====
// Package for the signed number writer of the character display.
// Holds the queue entry type and the display byte constants; no dependencies.
package lsnw_pkg;

	localparam logic [7:0] ASCII_ZERO   = 8'h30;
	localparam logic [7:0] ASCII_MINUS  = 8'h2D;
	localparam logic [7:0] ASCII_SPACE  = 8'h20;
	localparam logic [7:0] GLYPH_BLANK  = 8'h00;
	localparam logic [7:0] CMD_SET_ADDR = 8'h80;
	localparam logic [7:0] ROW1_OFFSET  = 8'h40;
	localparam logic [2:0] MAX_CHARS    = 3'd6;

	typedef struct packed {
		logic [7:0] sign_ch;
		logic [7:0] hund_ch;
		logic [7:0] tens_ch;
		logic [7:0] ones_ch;
		logic [3:0] column;
		logic       row;
		logic [2:0] length;
	} lsnw_item_t;

endpackage

// ===== hdl/lsnw_front.sv =====
// Front end: accepts samples, scales them and formats sign and decimal digits.
// Depends on lsnw_pkg; drops items with zero length and saturates the count.
module lsnw_front
	import lsnw_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  logic signed [15:0] value,
	input  logic [3:0]        column,
	input  logic              row,
	input  logic [2:0]        length,
	output logic              item_valid,
	input  logic              item_full,
	output lsnw_item_t        item
);

	logic        v_s1;
	logic [9:0]  q_s1;
	logic        minus_s1;
	logic [3:0]  col_s1;
	logic        row_s1;
	logic [2:0]  len_s1;
	logic        advance;
	logic        neg;
	logic [15:0] mag;
	logic [9:0]  q_in;
	logic [2:0]  hund;
	logic [9:0]  hund_sub;
	logic [6:0]  rem_h;
	logic [3:0]  tens;
	logic [6:0]  tens_sub;
	logic [3:0]  ones;

	assign advance = !v_s1 || !item_full;
	assign full    = !advance;

	assign neg  = value[15];
	assign mag  = neg ? (~value + 16'd1) : value;
	assign q_in = mag[15:6];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (advance) begin
			v_s1 <= push && (length != 3'd0);
		end
	end

	always_ff @(posedge clk) begin
		if (advance && push) begin
			q_s1     <= q_in;
			minus_s1 <= neg && (q_in != 10'd0);
			col_s1   <= column;
			row_s1   <= row;
			len_s1   <= (length > MAX_CHARS) ? MAX_CHARS : length;
		end
	end

	always_comb begin
		hund     = 3'd0;
		hund_sub = 10'd0;
		for (int k = 1; k <= 5; k++) begin
			if (q_s1 >= 10'(k * 100)) begin
				hund     = 3'(k);
				hund_sub = 10'(k * 100);
			end
		end
		rem_h    = 7'(q_s1 - hund_sub);
		tens     = 4'd0;
		tens_sub = 7'd0;
		for (int k = 1; k <= 9; k++) begin
			if (rem_h >= 7'(k * 10)) begin
				tens     = 4'(k);
				tens_sub = 7'(k * 10);
			end
		end
		ones = 4'(rem_h - tens_sub);
	end

	assign item_valid   = v_s1;
	assign item.sign_ch = minus_s1 ? ASCII_MINUS : ASCII_SPACE;
	assign item.hund_ch = ASCII_ZERO + {5'd0, hund};
	assign item.tens_ch = ASCII_ZERO + {4'd0, tens};
	assign item.ones_ch = ASCII_ZERO + {4'd0, ones};
	assign item.column  = col_s1;
	assign item.row     = row_s1;
	assign item.length  = len_s1;

endmodule

// ===== hdl/lsnw_fifo.sv =====
// Short queue of formatted items between the front end and the byte sequencer.
// Depends on lsnw_pkg for the entry type.
module lsnw_fifo
	import lsnw_pkg::*;
#(
	parameter int DEPTH = 2
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       wr_en,
	input  lsnw_item_t wr_data,
	output logic       is_full,
	input  logic       rd_en,
	output logic       not_empty,
	output lsnw_item_t rd_data
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	lsnw_item_t       mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_wr;
	logic             do_rd;

	assign is_full   = (count_q == CNT_W'(DEPTH));
	assign not_empty = (count_q != '0);
	assign do_wr     = wr_en && !is_full;
	assign do_rd     = rd_en && not_empty;
	assign rd_data   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

// ===== hdl/lsnw_back.sv =====
// Back end: walks each queued item, emitting an address command and a data byte
// per character into an output register. Depends on lsnw_pkg.
module lsnw_back
	import lsnw_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_ready,
	input  lsnw_item_t item,
	output logic       item_take,
	output logic       empty,
	input  logic       pop,
	output logic [7:0] lcd_byte,
	output logic       is_data,
	output logic       last
);

	lsnw_item_t cur_q;
	logic       busy_q;
	logic [2:0] idx_q;
	logic       phase_q;
	logic       ovalid_q;
	logic [7:0] byte_q;
	logic       is_data_q;
	logic       last_q;
	logic       adv;
	logic       is_last;
	logic       fin;
	logic       load;
	logic [7:0] glyph;
	logic [3:0] addr_col;

	assign adv      = busy_q && (!ovalid_q || pop);
	assign is_last  = ((idx_q + 3'd1) == cur_q.length);
	assign fin      = adv && phase_q && is_last;
	assign load     = item_ready && (!busy_q || fin);
	assign item_take = load;
	assign addr_col = cur_q.column + {1'b0, idx_q};

	always_comb begin
		case (idx_q)
			3'd0:    glyph = cur_q.sign_ch;
			3'd1:    glyph = cur_q.hund_ch;
			3'd2:    glyph = cur_q.tens_ch;
			3'd3:    glyph = cur_q.ones_ch;
			default: glyph = GLYPH_BLANK;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			idx_q    <= 3'd0;
			phase_q  <= 1'b0;
			ovalid_q <= 1'b0;
		end else begin
			if (load) begin
				busy_q  <= 1'b1;
				idx_q   <= 3'd0;
				phase_q <= 1'b0;
			end else if (fin) begin
				busy_q <= 1'b0;
			end else if (adv) begin
				phase_q <= !phase_q;
				if (phase_q) begin
					idx_q <= idx_q + 3'd1;
				end
			end
			if (adv) begin
				ovalid_q <= 1'b1;
			end else if (pop) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			cur_q <= item;
		end
		if (adv) begin
			if (phase_q) begin
				byte_q    <= glyph;
				is_data_q <= 1'b1;
				last_q    <= is_last;
			end else begin
				byte_q    <= CMD_SET_ADDR | (cur_q.row ? ROW1_OFFSET : 8'h00) | {4'd0, addr_col};
				is_data_q <= 1'b0;
				last_q    <= 1'b0;
			end
		end
	end

	assign empty    = !ovalid_q;
	assign lcd_byte = byte_q;
	assign is_data  = is_data_q;
	assign last     = last_q;

`ifndef SYNTHESIS
	a_last_on_data: assert property (@(posedge clk) disable iff (!arst_n)
		(ovalid_q && last_q) |-> is_data_q)
		else $error("Last marker on a command byte.");

	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (idx_q < cur_q.length))
		else $error("Character index beyond the item length.");

	a_cmd_then_reg: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && !phase_q) |=> (ovalid_q && !is_data_q))
		else $error("Address command did not reach the output register.");
`endif

endmodule

// ===== hdl/lcd_signed_number_writer.sv =====
// Signed number writer for a two-row character display: front end, queue, byte sequencer.
// An input goes through the front stage, queue and item register to the output register.
// Throughput: two bytes per character, so 2*length bytes per item, 12 at most,
// paced by the byte sequencer that emits one byte per cycle unless a byte waits unpopped.
// Reset (arst_n low) empties the front stage, the queue and the output register.
// Depends on lsnw_pkg, lsnw_front, lsnw_fifo and lsnw_back.
module lcd_signed_number_writer
	import lsnw_pkg::*;
#(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic signed [15:0] value,
	input  logic [3:0]         column,
	input  logic               row,
	input  logic [2:0]         length,
	output logic               empty,
	input  logic               pop,
	output logic [7:0]         lcd_byte,
	output logic               is_data,
	output logic               last
);

	lsnw_item_t fr_item;
	lsnw_item_t q_item;
	logic       fr_valid;
	logic       q_full;
	logic       q_not_empty;
	logic       q_take;

	lsnw_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.value      (value),
		.column     (column),
		.row        (row),
		.length     (length),
		.item_valid (fr_valid),
		.item_full  (q_full),
		.item       (fr_item)
	);

	lsnw_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (fr_valid),
		.wr_data   (fr_item),
		.is_full   (q_full),
		.rd_en     (q_take),
		.not_empty (q_not_empty),
		.rd_data   (q_item)
	);

	lsnw_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_ready (q_not_empty),
		.item       (q_item),
		.item_take  (q_take),
		.empty      (empty),
		.pop        (pop),
		.lcd_byte   (lcd_byte),
		.is_data    (is_data),
		.last       (last)
	);

endmodule
